// ===== src/h4_receive_deframer_macros.svh =====
// Assertion helpers shared by the deframer RTL.
`ifndef H4_RECEIVE_DEFRAMER_MACROS_SVH
`define H4_RECEIVE_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define H4D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define H4D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/h4d_pkg.sv =====
package h4d_pkg;

  localparam int QUEUE_DEPTH = 8;

  localparam int MAX_LEN_W = 17;
  localparam logic [MAX_LEN_W-1:0] MAX_FRAME_LENGTH_RESET = 17'd1028;

  // Register indexes on the configuration port.
  localparam logic CFG_RECEIVE_ENABLED  = 1'b0;
  localparam logic CFG_MAX_FRAME_LENGTH = 1'b1;

  // H4 packet types that open a frame.
  localparam logic [7:0] TYPE_ACL   = 8'h02;
  localparam logic [7:0] TYPE_SCO   = 8'h03;
  localparam logic [7:0] TYPE_EVENT = 8'h04;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN_TYPE = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE    = 2'd2;

  // One queued command: a single result, or a burst releasing a held header.
  typedef struct packed {
    logic            is_hdr;
    logic            kind;
    logic [7:0]      ptype;
    logic [7:0]      data;
    logic            last;   // for a header burst: payload length is zero
    logic [1:0]      err;
    logic [3:0][7:0] hdr;
    logic [2:0]      hsize;
  } cmd_t;

  function automatic logic [2:0] header_size_of(input logic [7:0] ptype);
    logic [2:0] hs;
    hs = 3'd0;
    if (ptype == TYPE_EVENT) hs = 3'd2;
    else if (ptype == TYPE_ACL) hs = 3'd4;
    else if (ptype == TYPE_SCO) hs = 3'd3;
    return hs;
  endfunction

endpackage

// ===== src/h4d_front.sv =====
module h4d_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [7:0]                      rx_byte,
  input  logic                            receive_enabled,
  input  logic [h4d_pkg::MAX_LEN_W-1:0]   max_frame_length,
  input  logic                            clear,
  output logic                            push,
  output h4d_pkg::cmd_t                   cmd,
  output logic                            busy
);

  localparam logic [1:0] PH_WAIT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]      phase, phase_next;
  logic [7:0]      cur_type, cur_type_next;
  logic [3:0][7:0] hdr_store;
  logic [2:0]      hcount, hcount_next;
  logic [2:0]      hsize, hsize_next;
  logic [15:0]     remaining, remaining_next;

  logic [3:0][7:0] hdr_m;
  logic [2:0]      hcount_inc;
  logic [15:0]     plen;
  logic [16:0]     total;
  logic [2:0]      hs_in;
  logic [15:0]     rem_dec;

  assign busy = (phase != PH_WAIT);
  assign hcount_inc = hcount + 3'd1;
  assign hs_in = h4d_pkg::header_size_of(rx_byte);
  assign rem_dec = remaining - 16'd1;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      hdr_m[j] = (hcount[1:0] == 2'(j)) ? rx_byte : hdr_store[j];
    end
    if (cur_type == h4d_pkg::TYPE_EVENT) begin
      plen = {8'h00, hdr_m[1]};
    end else if (cur_type == h4d_pkg::TYPE_ACL) begin
      plen = {hdr_m[3], hdr_m[2]};
    end else begin
      plen = {8'h00, hdr_m[2]};
    end
    total = {14'd0, hsize} + {1'b0, plen};
  end

  always_comb begin
    phase_next     = phase;
    cur_type_next  = cur_type;
    hcount_next    = hcount;
    hsize_next     = hsize;
    remaining_next = remaining;
    push           = 1'b0;
    cmd            = '0;
    cmd.ptype      = cur_type;
    cmd.hdr        = hdr_m;
    cmd.hsize      = hsize;
    if (clear) begin
      phase_next     = PH_WAIT;
      cur_type_next  = '0;
      hcount_next    = '0;
      hsize_next     = '0;
      remaining_next = '0;
    end else if (accept) begin
      if (!receive_enabled) begin
        phase_next     = PH_WAIT;
        cur_type_next  = '0;
        hcount_next    = '0;
        hsize_next     = '0;
        remaining_next = '0;
      end else begin
        unique case (phase)
          PH_WAIT: begin
            if (rx_byte != 8'h00) begin
              if (hs_in == 3'd0) begin
                // unknown type: report it and stay waiting
                push      = 1'b1;
                cmd.kind  = h4d_pkg::KIND_ERROR;
                cmd.ptype = rx_byte;
                cmd.err   = h4d_pkg::ERR_UNKNOWN_TYPE;
              end else begin
                cur_type_next = rx_byte;
                hsize_next    = hs_in;
                hcount_next   = '0;
                phase_next    = PH_HEADER;
              end
            end
          end
          PH_HEADER: begin
            hcount_next = hcount_inc;
            if (hcount_inc == hsize) begin
              push = 1'b1;
              if (total > max_frame_length) begin
                cmd.kind       = h4d_pkg::KIND_ERROR;
                cmd.err        = h4d_pkg::ERR_TOO_LARGE;
                phase_next     = PH_WAIT;
                cur_type_next  = '0;
                hcount_next    = '0;
                hsize_next     = '0;
                remaining_next = '0;
              end else begin
                cmd.is_hdr = 1'b1;
                cmd.kind   = h4d_pkg::KIND_FRAME;
                cmd.err    = h4d_pkg::ERR_NONE;
                cmd.last   = (plen == 16'd0);
                if (plen == 16'd0) begin
                  phase_next     = PH_WAIT;
                  cur_type_next  = '0;
                  hcount_next    = '0;
                  hsize_next     = '0;
                  remaining_next = '0;
                end else begin
                  remaining_next = plen;
                  phase_next     = PH_PAYLOAD;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            push           = 1'b1;
            cmd.kind       = h4d_pkg::KIND_FRAME;
            cmd.data       = rx_byte;
            cmd.last       = (rem_dec == 16'd0);
            remaining_next = rem_dec;
            if (rem_dec == 16'd0) begin
              phase_next    = PH_WAIT;
              cur_type_next = '0;
              hcount_next   = '0;
              hsize_next    = '0;
            end
          end
          default: begin
            phase_next     = PH_WAIT;
            cur_type_next  = '0;
            hcount_next    = '0;
            hsize_next     = '0;
            remaining_next = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      cur_type  <= '0;
      hcount    <= '0;
      hsize     <= '0;
      remaining <= '0;
    end else begin
      phase     <= phase_next;
      cur_type  <= cur_type_next;
      hcount    <= hcount_next;
      hsize     <= hsize_next;
      remaining <= remaining_next;
    end
  end

  // header bytes: no reset, each slot written before it is read
  always_ff @(posedge clk) begin
    if (accept && !clear && receive_enabled && phase == PH_HEADER) begin
      hdr_store[hcount[1:0]] <= rx_byte;
    end
  end

endmodule

// ===== src/h4d_fifo.sv =====
module h4d_fifo #(
  parameter int Depth = h4d_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  h4d_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output h4d_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  h4d_pkg::cmd_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == CntW'(Depth));
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if ((push && !full) && !do_pop) begin
        count <= count + CntW'(1);
      end else if (!(push && !full) && do_pop) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== src/h4d_back.sv =====
module h4d_back (
  input  logic          clk,
  input  logic          rst,
  input  h4d_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          kind,
  output logic [7:0]    packet_type,
  output logic [7:0]    frame_byte,
  output logic          first_of_frame,
  output logic          last_of_frame,
  output logic [1:0]    error_code
);

  h4d_pkg::cmd_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic [2:0]    hsize_m1;
  logic          final_beat;
  logic          advance;

  assign hsize_m1   = cur.hsize - 3'd1;
  assign final_beat = !cur.is_hdr || ({1'b0, idx} == hsize_m1);
  assign advance    = !cur_valid || (out_ready && final_beat);
  assign pop        = advance && head_valid;

  assign out_valid      = cur_valid;
  assign kind           = cur.kind;
  assign packet_type    = cur.ptype;
  assign frame_byte     = cur.is_hdr ? cur.hdr[idx] : cur.data;
  assign first_of_frame = cur.is_hdr && (idx == 2'd0);
  assign last_of_frame  = cur.is_hdr ? (cur.last && final_beat) : cur.last;
  assign error_code     = cur.err;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      cur_valid <= head_valid;
      idx       <= '0;
    end else if (cur_valid && out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      cur <= head;
    end
  end

endmodule

// ===== src/h4_receive_deframer.sv =====
// Channel   Dir  Beat contents
// s_*       in   tdata[7:0] rx_byte, one received H4 byte per transfer
// m_*       out  tdata packet_type/frame_byte/first/error, tuser kind,
//                tlast last_of_frame; one result per transfer
// cfg_*     in   register write: index 0 receive_enabled, 1 max_frame_length
//
// Steady rate is one byte per cycle while the queue has room: the front parser
// classifies a byte in the cycle it is accepted and queues at most one command for it.
// The back end sends one result per cycle while m_tready is high; a released header
// (2 to 4 results) occupies it, one result per header byte, which those bytes paid for.
// s_tready drops only when the eight-entry command queue is full; payload queued
// behind a header burst fills at most four entries, so only an output stall
// reaches the input, after the queue and the result register fill.
// rst is synchronous; it clears the parser, the queue and the result register,
// and loads receive disabled with a maximum frame length of 1028.
`include "h4_receive_deframer_macros.svh"

module h4_receive_deframer #(
  parameter int QueueDepth = h4d_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] packet_type, [15:8] frame_byte, [16] first_of_frame,
  // [18:17] error_code, [23:19] zero
  output logic [23:0]                   m_tdata,
  output logic                          m_tuser,   // [0] kind
  output logic                          m_tlast,   // last_of_frame
  // configuration writes
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [h4d_pkg::MAX_LEN_W-1:0] cfg_data
);

  logic                          receive_enabled;
  logic [h4d_pkg::MAX_LEN_W-1:0] max_frame_length;
  logic                          clear;

  logic          in_accept;
  logic          fifo_push, fifo_pop, fifo_not_empty, fifo_full;
  h4d_pkg::cmd_t fifo_wr, fifo_head;
  logic          front_busy;

  logic       kind, first_of_frame, last_of_frame;
  logic [7:0] packet_type, frame_byte;
  logic [1:0] error_code;

  logic is_error, err_shape_ok, is_start, start_clean_ok;

  // Configuration registers. Disabling receive also drops a partial frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      receive_enabled  <= 1'b0;
      max_frame_length <= h4d_pkg::MAX_FRAME_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        h4d_pkg::CFG_RECEIVE_ENABLED:  receive_enabled  <= cfg_data[0];
        h4d_pkg::CFG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign clear = cfg_we && (cfg_index == h4d_pkg::CFG_RECEIVE_ENABLED) && !cfg_data[0];

  // Hold the input only when the queue has no room for a command.
  assign s_tready  = !fifo_full;
  assign in_accept = s_tvalid && s_tready;

  h4d_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .rx_byte          (s_tdata),
    .receive_enabled  (receive_enabled),
    .max_frame_length (max_frame_length),
    .clear            (clear),
    .push             (fifo_push),
    .cmd              (fifo_wr),
    .busy             (front_busy)
  );

  h4d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .wr_cmd    (fifo_wr),
    .pop       (fifo_pop),
    .head      (fifo_head),
    .not_empty (fifo_not_empty),
    .full      (fifo_full)
  );

  h4d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (fifo_head),
    .head_valid     (fifo_not_empty),
    .pop            (fifo_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .kind           (kind),
    .packet_type    (packet_type),
    .frame_byte     (frame_byte),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .error_code     (error_code)
  );

  assign m_tdata = {5'd0, error_code, first_of_frame, frame_byte, packet_type};
  assign m_tuser = kind;
  assign m_tlast = last_of_frame;

  assign is_error       = m_tvalid && kind == h4d_pkg::KIND_ERROR;
  assign err_shape_ok   = frame_byte == 8'h00 && !first_of_frame && !last_of_frame &&
                          error_code != h4d_pkg::ERR_NONE;
  assign is_start       = m_tvalid && first_of_frame;
  assign start_clean_ok = kind == h4d_pkg::KIND_FRAME && error_code == h4d_pkg::ERR_NONE;

  // A command is never pushed into a full queue.
  `H4D_ASSERT_IMP(a_no_overflow, fifo_push, !fifo_full, "command queue overflow")
  // Error results carry no byte and no frame marks.
  `H4D_ASSERT_IMP(a_error_shape, is_error, err_shape_ok, "malformed error result")
  // A frame start is always a clean frame byte.
  `H4D_ASSERT_IMP(a_first_clean, is_start, start_clean_ok, "first byte flagged as error")
  // Disabling receive leaves the parser waiting for a type byte.
  `H4D_ASSERT_NXT(a_disable_clears, clear, !front_busy, "parser not cleared on disable")

endmodule
